### rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared types, constants and knot tables of the heater setpoint regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hsr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DUTY_W     = 10;
    localparam int DELTA_W    = 8;
    localparam int REQ_W      = 7;
    localparam int ADC_W      = 11;
    localparam int SEG_W      = 4;
    localparam int SHIFT_W    = 2;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COOL_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BELOW_RANGE_DELTA = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABOVE_RANGE_DELTA = 2'd3;

    localparam logic [7:0] KNOT_FIRST = 8'd25;
    localparam logic [7:0] KNOT_LAST  = 8'd205;

    typedef struct packed {
        logic               take_set;
        logic               take_tick;
        logic               div_step;
        logic               div_last;
        logic [SHIFT_W-1:0] div_shift;
    } hsr_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [SEG_W-1:0] idx;
    } hsr_knot_t;

    function automatic logic [7:0] knot_adc(input logic [SEG_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'd25;
            4'd1:    v = 8'd50;
            4'd2:    v = 8'd75;
            4'd3:    v = 8'd100;
            4'd4:    v = 8'd125;
            4'd5:    v = 8'd150;
            4'd6:    v = 8'd165;
            4'd7:    v = 8'd175;
            4'd8:    v = 8'd190;
            4'd9:    v = 8'd205;
            default: v = 8'd205;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] knot_pwm(input logic [SEG_W-1:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd20;
            4'd1:    v = 9'd50;
            4'd2:    v = 9'd95;
            4'd3:    v = 9'd135;
            4'd4:    v = 9'd180;
            4'd5:    v = 9'd245;
            4'd6:    v = 9'd265;
            4'd7:    v = 9'd295;
            4'd8:    v = 9'd350;
            4'd9:    v = 9'd400;
            default: v = 9'd400;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] knot_span(input logic [SEG_W-1:0] idx);
        logic [4:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: v = 5'd25;
            4'd5:    v = 5'd15;
            4'd6:    v = 5'd10;
            4'd7:    v = 5'd15;
            4'd8:    v = 5'd15;
            default: v = 5'd15;
        endcase
        return v;
    endfunction

    function automatic hsr_knot_t req_knot(input logic [REQ_W-1:0] req);
        hsr_knot_t k;
        k.hit = 1'b1;
        case (req)
            7'd10:   k.idx = 4'd0;
            7'd20:   k.idx = 4'd1;
            7'd30:   k.idx = 4'd2;
            7'd40:   k.idx = 4'd3;
            7'd50:   k.idx = 4'd4;
            7'd60:   k.idx = 4'd5;
            7'd70:   k.idx = 4'd6;
            7'd80:   k.idx = 4'd7;
            7'd90:   k.idx = 4'd8;
            7'd100:  k.idx = 4'd9;
            default:
            begin
                k.hit = 1'b0;
                k.idx = 4'd0;
            end
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/hsr_in_if.sv
// ----------------------------------------------------------------------------
// hsr_in_if
// Command channel: set request or measurement tick, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsr_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [6:0]        target_delta;
    logic signed [10:0] adc_diff;

    modport source (output valid, output cmd, output target_delta, output adc_diff,
                    input ready);
    modport sink   (input valid, input cmd, input target_delta, input adc_diff,
                    output ready);
endinterface

`default_nettype wire

### rtl/hsr_out_if.sv
// ----------------------------------------------------------------------------
// hsr_out_if
// Result channel: duty, fan state and measured delta, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsr_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] pwm_duty;
    logic       fan_on;
    logic [7:0] measured_delta;

    modport source (output valid, output pwm_duty, output fan_on, output measured_delta,
                    input ready);
    modport sink   (input valid, input pwm_duty, input fan_on, input measured_delta,
                    output ready);
endinterface

`default_nettype wire

### rtl/heater_setpoint_regulator.sv
// ----------------------------------------------------------------------------
// heater_setpoint_regulator
// Heater setpoint regulator: set requests load the table setpoint, ticks
// choose the PWM duty and fan state and report the interpolated delta.
//
//   channel   modport          contents
//   cmd_ch    hsr_in_if.sink   cmd, target_delta, adc_diff
//   res_ch    hsr_out_if.source pwm_duty, fan_on, measured_delta
//   cfg       write port       cfg_we, cfg_index, cfg_data
//
// A set transaction gives no result.
// A tick transaction is taken, then runs four divider steps (one quotient
// bit each), then the result is held until taken.
// No new transaction is taken while a tick is in work or its result waits.
// Reset loads the register defaults and clears the setpoint and fan state.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_setpoint_regulator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hsr_in_if.sink                              cmd_ch,
    hsr_out_if.source                           res_ch,
    input  wire logic                           cfg_we,
    input  wire logic [hsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hsr_pkg::*;

    hsr_cmd_t ctl;

    hsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_cmd    (cmd_ch.cmd),
        .in_ready  (cmd_ch.ready),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .ctl       (ctl)
    );

    hsr_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .target_delta   (cmd_ch.target_delta),
        .adc_diff       (cmd_ch.adc_diff),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pwm_duty       (res_ch.pwm_duty),
        .fan_on         (res_ch.fan_on),
        .measured_delta (res_ch.measured_delta)
    );

endmodule

`default_nettype wire

### rtl/hsr_ctrl.sv
// ----------------------------------------------------------------------------
// hsr_ctrl
// Controller: input/output handshake and sequencing of the divider steps.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_cmd,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hsr_pkg::hsr_cmd_t      ctl
);
    import hsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [SHIFT_W-1:0] cnt_reg;
    logic [SHIFT_W-1:0] cnt_next;
    logic               take;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign take      = in_valid && in_ready;

    always_comb
    begin
        ctl.take_set  = take && (in_cmd == CMD_SET);
        ctl.take_tick = take && (in_cmd == CMD_TICK);
        ctl.div_step  = (state_reg == S_DIV);
        ctl.div_last  = (state_reg == S_DIV) && (cnt_reg == '0);
        ctl.div_shift = cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && (in_cmd == CMD_TICK))
                begin
                    state_next = S_DIV;
                    cnt_next   = '1;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open together");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take_tick |=> (!in_ready && ctl.div_step && (ctl.div_shift == '1)))
        else $error("tick transaction did not start the divider");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

endmodule

`default_nettype wire

### rtl/hsr_dpath.sv
// ----------------------------------------------------------------------------
// hsr_dpath
// Datapath: settings, setpoint state, duty and fan choice, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hsr_pkg::hsr_cmd_t             ctl,
    input  wire logic [hsr_pkg::REQ_W-1:0]     target_delta,
    input  wire logic signed [hsr_pkg::ADC_W-1:0] adc_diff,
    input  wire logic                          cfg_we,
    input  wire logic [hsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hsr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [hsr_pkg::DUTY_W-1:0]         pwm_duty,
    output logic                               fan_on,
    output logic [hsr_pkg::DELTA_W-1:0]        measured_delta
);
    import hsr_pkg::*;

    logic [7:0]       cool_thr_reg;
    logic [9:0]       duty_step_reg;
    logic [7:0]       below_delta_reg;
    logic [7:0]       above_delta_reg;

    logic [7:0]       target_adc_reg;
    logic [8:0]       base_pwm_reg;
    logic             cooling_reg;
    logic [REQ_W-1:0] last_req_reg;
    logic             fan_reg;
    logic             fan_next;

    logic [DUTY_W-1:0]  duty_reg;
    logic [DUTY_W-1:0]  duty_next;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEG_W-1:0]   seg_next;
    logic [7:0]         num_reg;
    logic [7:0]         num_next;
    logic [7:0]         num_div;
    logic [4:0]         span_reg;
    logic [3:0]         quo_reg;
    logic [3:0]         quo_next;
    logic               below_reg;
    logic               above_reg;
    logic               off_reg;
    logic [DELTA_W-1:0] meas_reg;
    logic [DELTA_W-1:0] meas_next;

    hsr_knot_t          knot;
    logic signed [11:0] x12;
    logic signed [11:0] tgt12;
    logic signed [11:0] cool_lim;
    logic signed [11:0] off12;
    logic [4:0]         off5;
    logic [8:0]         stepped;
    logic [7:0]         trial;
    logic [7:0]         base10;

    assign knot  = req_knot(target_delta);
    assign x12   = {adc_diff[ADC_W-1], adc_diff};
    assign tgt12 = $signed({4'b0, target_adc_reg});
    assign cool_lim = tgt12 - $signed({4'b0, cool_thr_reg});

    always_comb
    begin
        seg_next = '0;
        for (int i = 1; i < 9; i++)
        begin
            if (x12 >= $signed({4'b0, knot_adc(SEG_W'(i))}))
            begin
                seg_next = seg_next + 1'b1;
            end
        end
    end

    assign off12    = x12 - $signed({4'b0, knot_adc(seg_next)});
    assign off5     = off12[4:0];
    assign num_next = 8'({3'b0, off5} << 3) + 8'({3'b0, off5} << 1);

    always_comb
    begin
        if (x12 > tgt12)
        begin
            stepped = ({1'b0, base_pwm_reg} > duty_step_reg)
                      ? 9'({1'b0, base_pwm_reg} - duty_step_reg) : 9'd0;
        end
        else
        begin
            stepped = base_pwm_reg;
        end
    end

    always_comb
    begin
        fan_next  = fan_reg;
        duty_next = {1'b0, stepped};
        if (base_pwm_reg == '0)
        begin
            duty_next = '0;
        end
        else if (cooling_reg)
        begin
            if (x12 > cool_lim)
            begin
                fan_next  = 1'b1;
                duty_next = DUTY_W'(1);
            end
            else
            begin
                fan_next = 1'b0;
            end
        end
    end

    assign trial = 8'({3'b0, span_reg} << ctl.div_shift);

    always_comb
    begin
        num_div  = num_reg;
        quo_next = quo_reg;
        if (num_reg >= trial)
        begin
            num_div = num_reg - trial;
            quo_next[ctl.div_shift] = 1'b1;
        end
    end

    assign base10 = 8'({4'b0, seg_reg} << 3) + 8'({4'b0, seg_reg} << 1) + 8'd10;

    always_comb
    begin
        if (off_reg)
        begin
            meas_next = '0;
        end
        else if (below_reg)
        begin
            meas_next = below_delta_reg;
        end
        else if (above_reg)
        begin
            meas_next = above_delta_reg;
        end
        else
        begin
            meas_next = base10 + {4'b0, quo_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_thr_reg    <= 8'd10;
            duty_step_reg   <= 10'd10;
            below_delta_reg <= 8'd0;
            above_delta_reg <= 8'd255;
            target_adc_reg  <= '0;
            base_pwm_reg    <= '0;
            cooling_reg     <= 1'b0;
            last_req_reg    <= '0;
            fan_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COOL_THRESHOLD:    cool_thr_reg    <= cfg_data[7:0];
                    REG_DUTY_STEP:         duty_step_reg   <= cfg_data;
                    REG_BELOW_RANGE_DELTA: below_delta_reg <= cfg_data[7:0];
                    REG_ABOVE_RANGE_DELTA: above_delta_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (ctl.take_set)
            begin
                if (target_delta == '0)
                begin
                    base_pwm_reg   <= '0;
                    target_adc_reg <= '0;
                end
                else if (target_delta != last_req_reg)
                begin
                    cooling_reg  <= !(target_delta > last_req_reg);
                    last_req_reg <= target_delta;
                    if (knot.hit)
                    begin
                        target_adc_reg <= knot_adc(knot.idx);
                        base_pwm_reg   <= knot_pwm(knot.idx);
                    end
                end
            end
            if (ctl.take_tick)
            begin
                fan_reg <= fan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_tick)
        begin
            duty_reg  <= duty_next;
            seg_reg   <= seg_next;
            num_reg   <= num_next;
            span_reg  <= knot_span(seg_next);
            quo_reg   <= '0;
            below_reg <= (x12 < $signed({4'b0, KNOT_FIRST}));
            above_reg <= (x12 > $signed({4'b0, KNOT_LAST}));
            off_reg   <= (base_pwm_reg == '0);
        end
        else if (ctl.div_step)
        begin
            num_reg <= num_div;
            quo_reg <= quo_next;
            if (ctl.div_last)
            begin
                meas_reg <= meas_next;
            end
        end
    end

    assign pwm_duty       = duty_reg;
    assign fan_on         = fan_reg;
    assign measured_delta = meas_reg;

    a_meas_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_last && !off_reg && !below_reg && !above_reg) |=> (meas_reg <= 8'd100))
        else $error("interpolated delta out of table range");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heater setpoint regulator. Set and tick
// transactions go in on the command channel with random gaps, results are
// taken with random back-pressure and compared field by field against an
// in-bench model of the setpoint, fan and interpolation rules. Register
// settings are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;

    import hsr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               fan;
        logic [DELTA_W-1:0] delta;
    } heat_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hsr_in_if  cmd_if ();
    hsr_out_if res_if ();

    heater_setpoint_regulator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_if),
        .res_ch    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int knot_x    [0:9] = '{25, 50, 75, 100, 125, 150, 165, 175, 190, 205};
    int knot_duty [0:9] = '{20, 50, 95, 135, 180, 245, 265, 295, 350, 400};

    logic [7:0]  cool_thr_m;
    logic [9:0]  duty_step_m;
    logic [7:0]  below_m;
    logic [7:0]  above_m;
    logic [7:0]  target_adc_m;
    logic [8:0]  base_pwm_m;
    logic        cooling_m;
    logic [6:0]  last_req_m;
    logic        fan_m;

    heat_result_t expected_q [$];

    int  cycle_cnt    = 0;
    int  fail_cnt     = 0;
    int  results_seen = 0;
    int  tick_cnt     = 0;
    int  set_cnt      = 0;
    int  cfg_writes   = 0;
    int  stall_asks   = 0;
    int  stall_taken  = 0;
    bit  tx_quiet     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] interp_reading(input int x);
        int i;
        int d;
        if (x < knot_x[0])
            return below_m;
        if (x > knot_x[9])
            return above_m;
        d = 100;
        for (i = 0; i < 9; i++)
            if (x >= knot_x[i] && x < knot_x[i + 1])
                d = (i + 1) * 10 + (10 * (x - knot_x[i])) / (knot_x[i + 1] - knot_x[i]);
        return d[7:0];
    endfunction

    function automatic heat_result_t predict_tick(input logic signed [10:0] adc);
        heat_result_t r;
        int x;
        int duty;
        int tgt;
        int base;
        x    = adc;
        tgt  = target_adc_m;
        base = base_pwm_m;
        r.delta = '0;
        if (base == 0)
            duty = 0;
        else
        begin
            r.delta = interp_reading(x);
            if (cooling_m && x > tgt - int'(cool_thr_m))
            begin
                fan_m = 1'b1;
                duty  = 1;
            end
            else
            begin
                if (cooling_m)
                    fan_m = 1'b0;
                if (x > tgt)
                    duty = (base > int'(duty_step_m)) ? base - int'(duty_step_m) : 0;
                else
                    duty = base;
            end
        end
        if (duty > 1023)
            duty = 1023;
        r.duty = duty[9:0];
        r.fan  = fan_m;
        return r;
    endfunction

    function automatic void apply_setpoint(input logic [6:0] req);
        int k;
        if (req == 0)
        begin
            base_pwm_m   = '0;
            target_adc_m = '0;
        end
        else if (req != last_req_m)
        begin
            cooling_m  = !(req > last_req_m);
            last_req_m = req;
            if (req % 10 == 0 && req <= 100)
            begin
                k = req / 10 - 1;
                target_adc_m = knot_x[k][7:0];
                base_pwm_m   = knot_duty[k][8:0];
            end
        end
    endfunction

    function automatic int tx_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_item(input logic cmd, input logic [6:0] req,
                             input logic signed [10:0] adc);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.cmd          <= cmd;
        cmd_if.target_delta <= req;
        cmd_if.adc_diff     <= adc;
        @(posedge clk);
        while (cmd_if.ready !== 1'b1)
            @(posedge clk);
        if (cmd == CMD_TICK)
        begin
            expected_q.push_back(predict_tick(adc));
            tick_cnt++;
        end
        else
        begin
            apply_setpoint(req);
            set_cnt++;
        end
    endtask

    task automatic send_tick(input int x);
        send_item(CMD_TICK, 7'($urandom_range(0, 127)), 11'(x));
    endtask

    task automatic send_set(input int req);
        send_item(CMD_SET, 7'(req), 11'($urandom_range(0, 2047)));
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COOL_THRESHOLD:    cool_thr_m  = value[7:0];
            REG_DUTY_STEP:         duty_step_m = value[9:0];
            REG_BELOW_RANGE_DELTA: below_m     = value[7:0];
            REG_ABOVE_RANGE_DELTA: above_m     = value[7:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_settings(input int thr, input int step, input int lo, input int hi);
        settle();
        write_reg(REG_COOL_THRESHOLD, thr);
        write_reg(REG_DUTY_STEP, step);
        write_reg(REG_BELOW_RANGE_DELTA, lo);
        write_reg(REG_ABOVE_RANGE_DELTA, hi);
    endtask

    task automatic run_traffic(input int n);
        int i;
        int r;
        int x;
        for (i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            if (base_pwm_m == 0 && $urandom_range(0, 3) != 0)
                send_set(10 * $urandom_range(1, 10));
            else if ($urandom_range(0, 9) < 3)
            begin
                r = $urandom_range(0, 19);
                if (r < 11)
                    send_set(10 * $urandom_range(1, 10));
                else if (r < 13)
                    send_set(0);
                else if (r < 15)
                    send_set(last_req_m);
                else
                    send_set($urandom_range(0, 127));
            end
            else
            begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    x = int'(target_adc_m) + $urandom_range(0, 60) - 30;
                else if (r == 1)
                    x = int'(target_adc_m) - int'(cool_thr_m) + $urandom_range(0, 6) - 3;
                else if (r == 2)
                    x = $urandom_range(0, 255);
                else
                    x = $urandom_range(0, 2047);
                send_tick(x);
            end
        end
        tx_quiet = 1'b0;
    endtask

    task automatic test_heater_off();
        send_tick(-1024);
        send_tick(1023);
    endtask

    task automatic test_warm_up();
        send_set(50);
        send_tick(24);
        send_tick(25);
        send_tick(50);
        send_tick(51);
        send_tick(205);
        send_tick(206);
        send_set(100);
        send_tick(0);
    endtask

    task automatic test_cool_down();
        send_set(20);
        send_tick(40);
        send_tick(41);
        send_tick(-1024);
    endtask

    task automatic test_repeat_and_clear();
        send_set(20);
        send_set(0);
        send_tick(100);
        send_set(20);
        send_tick(30);
        send_set(127);
        send_set(55);
        send_set(10);
        send_tick(26);
    endtask

    task automatic test_register_extremes();
        int p;
        load_settings(0, 0, 0, 0);
        run_traffic(300);
        load_settings(255, 1023, 255, 255);
        run_traffic(300);
        load_settings(10, 10, 0, 255);
        run_traffic(300);
        for (p = 0; p < 3; p++)
        begin
            load_settings($urandom_range(0, 255),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 400)
                                                      : $urandom_range(0, 1023),
                          $urandom_range(0, 255), $urandom_range(0, 255));
            run_traffic(300);
        end
    endtask

    task automatic test_result_stall();
        int i;
        send_set(60);
        stall_asks++;
        tx_quiet = 1'b1;
        for (i = 0; i < 30; i++)
            send_tick($urandom_range(100, 220));
        tx_quiet = 1'b0;
    endtask

    // result sink: random ready phases, plus a long hold-off on request
    initial
    begin
        int phase_left;
        int stall_left;
        logic rdy;
        phase_left   = 0;
        stall_left   = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_taken != stall_asks)
            begin
                stall_taken  = stall_taken + 1;
                stall_left   = STALL_CYCLES;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   = stall_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (phase_left > 0)
                phase_left = phase_left - 1;
            else
            begin
                rdy = ($urandom_range(0, 3) != 0);
                res_if.ready <= rdy;
                if (rdy)
                    phase_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 12);
                else if ($urandom_range(0, 9) < 8)
                    phase_left = $urandom_range(0, 3);
                else
                    phase_left = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        heat_result_t exp_r;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: duty %0d fan %0b delta %0d",
                             res_if.pwm_duty, res_if.fan_on, res_if.measured_delta);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (res_if.pwm_duty !== exp_r.duty || res_if.fan_on !== exp_r.fan ||
                    res_if.measured_delta !== exp_r.delta)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch at result %0d: duty %0d/%0d fan %0b/%0b %s %0d/%0d",
                                 results_seen, exp_r.duty, res_if.pwm_duty, exp_r.fan,
                                 res_if.fan_on, "delta (expected/actual)", exp_r.delta,
                                 res_if.measured_delta);
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, expected_q.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        cmd_if.valid        <= 1'b0;
        cmd_if.cmd          <= CMD_SET;
        cmd_if.target_delta <= '0;
        cmd_if.adc_diff     <= '0;
        cool_thr_m   = 8'd10;
        duty_step_m  = 10'd10;
        below_m      = 8'd0;
        above_m      = 8'd255;
        target_adc_m = '0;
        base_pwm_m   = '0;
        cooling_m    = 1'b0;
        last_req_m   = '0;
        fan_m        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_heater_off();
        test_warm_up();
        test_cool_down();
        test_repeat_and_clear();
        test_register_extremes();
        test_result_stall();

        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            fail_cnt++;

        $display("covered %0d set and %0d tick transactions, %0d results checked",
                 set_cnt, tick_cnt, results_seen);
        $display("register writes %0d over six settings, one long result stall, errors %0d",
                 cfg_writes, fail_cnt);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
